// File: rtl/core/spimf_pkg.sv
// Package for the SPI master FIFO controller: sizes, register offsets,
// status bits, run phase type and the result record. No dependencies.
package spimf_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int REG_WORDS  = 20;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RIX_W      = $clog2(REG_WORDS);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_CS    = 2'd3;

    localparam logic [7:0] ADDR_CTRL   = 8'h00;
    localparam logic [7:0] ADDR_CFG    = 8'h04;
    localparam logic [7:0] ADDR_STATUS = 8'h08;
    localparam logic [7:0] ADDR_TXDATA = 8'h10;
    localparam logic [7:0] ADDR_RXDATA = 8'h20;
    localparam logic [7:0] ADDR_RXCNT  = 8'h34;
    localparam logic [7:0] ADDR_TXCNT  = 8'h4c;
    localparam logic [7:0] ADDR_LIMIT  = 8'h50;

    localparam int IX_CTRL   = 0;
    localparam int IX_CFG    = 1;
    localparam int IX_STATUS = 2;
    localparam int IX_PIN    = 3;
    localparam int IX_RXCNT  = 13;
    localparam int IX_TXCNT  = 19;

    localparam logic [31:0] ST_RXREADY  = 32'h0000_0001;
    localparam logic [31:0] ST_TXEMPTY  = 32'h0000_0002;
    localparam logic [31:0] ST_RXOVF    = 32'h0000_0008;
    localparam logic [31:0] ST_COMPLETE = 32'h0040_0000;

    localparam logic [1:0] MODE_INVALID = 2'd0;
    localparam logic [1:0] MODE_DMA     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TX   = 2'd1,
        PH_FILL = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        shift_valid;
        logic [7:0]  shift_byte;
        logic        busy_res;
        logic        ignored;
        logic        irq_level;
        logic        cs_out;
    } spimf_result_t;

endpackage

// File: rtl/core/spimf_core.sv
// Register file, TX/RX FIFOs and transfer sequencer of the SPI master.
// Depends on spimf_pkg. Updates all state on each accepted request.
module spimf_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [1:0]             command,
    input  logic [7:0]             address,
    input  logic [31:0]            write_data,
    input  logic [7:0]             reply_byte,
    input  logic                   cs_level,
    output spimf_pkg::spimf_result_t result
);
    import spimf_pkg::*;

    logic [31:0]      rf_reg [REG_WORDS];
    logic [31:0]      txq_reg [FIFO_DEPTH];
    logic [31:0]      rxq_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] tx_head_reg, rx_head_reg;
    logic [LVL_W-1:0] tx_level_reg, rx_level_reg;
    phase_t           phase_reg;
    logic [31:0]      shift_word_reg, gather_word_reg;
    logic [1:0]       byte_index_reg;

    logic [31:0]      rf_next [REG_WORDS];
    logic [PTR_W-1:0] tx_head_next, rx_head_next;
    logic [LVL_W-1:0] tx_level_next, rx_level_next;
    phase_t           phase_next;
    logic [31:0]      shift_word_next, gather_word_next;
    logic [1:0]       byte_index_next;

    logic             tx_push, rx_push;
    logic [PTR_W-1:0] tx_push_ix, rx_push_ix;
    logic [31:0]      tx_push_w, rx_push_w, pop_w, wval, rdata, mask;
    logic             ev, ign, run_req, do_next, next_tx, stop, was_tx;
    logic [7:0]       eb;
    logic [2:0]       nb;
    logic [RIX_W-1:0] ix;
    logic [1:0]       mode;

    function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] h, logic [LVL_W-1:0] l);
        logic [LVL_W:0] s;
        s = {{(LVL_W+1-PTR_W){1'b0}}, h} + {1'b0, l};
        if (s >= (LVL_W+1)'(FIFO_DEPTH)) s = s - (LVL_W+1)'(FIFO_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < REG_WORDS; i++) rf_next[i] = rf_reg[i];
        tx_head_next = tx_head_reg;
        rx_head_next = rx_head_reg;
        tx_level_next = tx_level_reg;
        rx_level_next = rx_level_reg;
        phase_next = phase_reg;
        shift_word_next = shift_word_reg;
        gather_word_next = gather_word_reg;
        byte_index_next = byte_index_reg;
        tx_push = 1'b0; tx_push_ix = '0; tx_push_w = '0;
        rx_push = 1'b0; rx_push_ix = '0; rx_push_w = '0;
        ev = 1'b0; eb = '0; ign = 1'b0; rdata = '0;
        run_req = 1'b0; do_next = 1'b0; next_tx = 1'b0; stop = 1'b0;
        was_tx = (phase_reg == PH_TX);
        wval = write_data;
        ix = address[RIX_W+1:2];
        pop_w = '0;
        case (rf_reg[IX_CFG][16:15])
            2'd0:    nb = 3'd1;
            2'd1:    nb = 3'd2;
            default: nb = 3'd4;
        endcase

        if (command == CMD_CS) begin
            rf_next[IX_PIN][1] = cs_level;
        end else if (command == CMD_REPLY) begin
            if (phase_reg != PH_IDLE) begin
                gather_word_next = {gather_word_reg[23:0], reply_byte};
                if ({1'b0, byte_index_reg} + 3'd1 < nb) begin
                    byte_index_next = byte_index_reg + 2'd1;
                    ev = 1'b1;
                    if (was_tx) begin
                        shift_word_next = shift_word_reg >> 8;
                        eb = shift_word_next[7:0];
                    end else begin
                        eb = 8'hFF;
                    end
                end else begin
                    if (was_tx) begin
                        rf_next[IX_TXCNT] = rf_reg[IX_TXCNT] - 32'd1;
                        if (tx_level_reg == '0) rf_next[IX_STATUS] |= ST_TXEMPTY;
                        if (rf_reg[IX_RXCNT] == '0) begin
                            do_next = 1'b1; next_tx = 1'b1; stop = 1'b1;
                        end
                    end
                    if (!stop) begin
                        if (rx_level_reg >= LVL_W'(FIFO_DEPTH)) begin
                            rf_next[IX_STATUS] |= ST_RXOVF;
                            phase_next = PH_IDLE;
                        end else begin
                            rx_push = 1'b1;
                            rx_push_ix = ptr_add(rx_head_reg, rx_level_reg);
                            rx_push_w = gather_word_next;
                            rx_level_next = rx_level_reg + LVL_W'(1);
                            rf_next[IX_RXCNT] = rf_reg[IX_RXCNT] - 32'd1;
                            rf_next[IX_STATUS] |= ST_RXREADY;
                            do_next = 1'b1; next_tx = was_tx;
                        end
                    end
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            ign = 1'b1;
        end else if (command == CMD_WRITE) begin
            if (address < ADDR_LIMIT) begin
                case (address)
                    ADDR_CTRL: begin
                        if (wval[2]) begin
                            tx_head_next = '0; tx_level_next = '0; wval[2] = 1'b0;
                        end
                        if (wval[3]) begin
                            rx_head_next = '0; rx_level_next = '0; wval[3] = 1'b0;
                        end
                        run_req = wval[0];
                    end
                    ADDR_STATUS: wval = rf_reg[IX_STATUS] & ~write_data;
                    ADDR_TXDATA: begin
                        if (tx_level_reg >= LVL_W'(FIFO_DEPTH)) begin
                            wval = '0;
                        end else begin
                            tx_push = 1'b1;
                            tx_push_ix = ptr_add(tx_head_reg, tx_level_reg);
                            tx_push_w = (nb == 3'd1) ? {24'd0, write_data[7:0]} :
                                        (nb == 3'd2) ? {16'd0, write_data[15:0]} :
                                        write_data;
                            tx_level_next = tx_level_reg + LVL_W'(1);
                            run_req = 1'b1;
                        end
                    end
                    ADDR_CFG, ADDR_RXCNT, ADDR_TXCNT: run_req = 1'b1;
                    default: ;
                endcase
                rf_next[ix] = wval;
            end
        end else begin
            if (address < ADDR_LIMIT) begin
                rdata = rf_reg[ix];
                if (address == ADDR_RXDATA) begin
                    if (rx_level_reg == '0) begin
                        rdata = '0;
                    end else begin
                        rdata = rxq_reg[rx_head_reg];
                        rx_head_next = ptr_add(rx_head_reg, LVL_W'(1));
                        rx_level_next = rx_level_reg - LVL_W'(1);
                        run_req = (rx_level_next == '0);
                    end
                end else if (address == ADDR_STATUS) begin
                    rdata[10:6] = 5'(tx_level_reg);
                    rdata[15:11] = 5'(rx_level_reg);
                end
            end
        end

        // Run start uses the configuration and counts as just written.
        mode = rf_next[IX_CFG][6:5];
        if (run_req && mode != MODE_DMA && mode != MODE_INVALID && rf_next[IX_CTRL][0]
            && (rf_next[IX_RXCNT] | rf_next[IX_TXCNT]) != '0) begin
            if (tx_level_next == '0) rf_next[IX_STATUS] |= ST_TXEMPTY;
            do_next = 1'b1; next_tx = 1'b1;
        end

        if (do_next) begin
            // A word pushed by this same request may be the one popped.
            pop_w = (tx_push && tx_push_ix == tx_head_next) ? tx_push_w
                                                           : txq_reg[tx_head_next];
            if (next_tx && rf_next[IX_TXCNT] != '0 && tx_level_next != '0) begin
                shift_word_next = pop_w;
                tx_head_next = ptr_add(tx_head_next, LVL_W'(1));
                tx_level_next = tx_level_next - LVL_W'(1);
                gather_word_next = '0; byte_index_next = '0;
                phase_next = PH_TX;
                ev = 1'b1; eb = pop_w[7:0];
            end else if (rx_level_next < LVL_W'(FIFO_DEPTH) && rf_next[IX_RXCNT] != '0
                         && rf_next[IX_CFG][0]) begin
                gather_word_next = '0; byte_index_next = '0;
                phase_next = PH_FILL;
                ev = 1'b1; eb = 8'hFF;
            end else begin
                phase_next = PH_IDLE;
                if (rf_next[IX_RXCNT] == '0 && rf_next[IX_TXCNT] == '0)
                    rf_next[IX_STATUS] |= ST_COMPLETE;
            end
        end

        mask = '0;
        if (rf_next[IX_CFG][7])  mask |= ST_RXREADY;
        if (rf_next[IX_CFG][8])  mask |= ST_TXEMPTY;
        if (rf_next[IX_CFG][21]) mask |= ST_COMPLETE;

        result.read_data   = rdata;
        result.shift_valid = ev;
        result.shift_byte  = eb;
        result.busy_res    = (phase_next != PH_IDLE);
        result.ignored     = ign;
        result.irq_level   = |(rf_next[IX_STATUS] & mask);
        result.cs_out      = rf_next[IX_PIN][1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_WORDS; i++) rf_reg[i] <= '0;
            tx_head_reg <= '0;
            rx_head_reg <= '0;
            tx_level_reg <= '0;
            rx_level_reg <= '0;
            phase_reg <= PH_IDLE;
            shift_word_reg <= '0;
            gather_word_reg <= '0;
            byte_index_reg <= '0;
        end else if (accept) begin
            for (int i = 0; i < REG_WORDS; i++) rf_reg[i] <= rf_next[i];
            tx_head_reg <= tx_head_next;
            rx_head_reg <= rx_head_next;
            tx_level_reg <= tx_level_next;
            rx_level_reg <= rx_level_next;
            phase_reg <= phase_next;
            shift_word_reg <= shift_word_next;
            gather_word_reg <= gather_word_next;
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && tx_push) txq_reg[tx_push_ix] <= tx_push_w;
        if (accept && rx_push) rxq_reg[rx_push_ix] <= rx_push_w;
    end

    a_tx_level: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_level_reg <= LVL_W'(FIFO_DEPTH)) else $error("TX level beyond depth");
    a_rx_level: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_level_reg <= LVL_W'(FIFO_DEPTH)) else $error("RX level beyond depth");
    a_ignored_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.ignored |=> $stable(tx_level_reg) && $stable(rx_level_reg))
        else $error("dropped request changed FIFO levels");
    a_busy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (phase_reg != PH_IDLE) == $past(result.busy_res))
        else $error("busy flag disagrees with run phase");

endmodule

// File: rtl/core/spi_master_fifo_controller.sv
// Top level of the SPI master FIFO controller: stream ports and the
// result register. Depends on spimf_pkg and spimf_core.
//
// Usage: each request on the s_ channel is a register read, a register
// write, a reply byte received from the peripheral, or a chip-select input
// level, selected by s_tuser. Every request yields exactly one result on the
// m_ channel carrying the read data, the next byte to shift out (if any),
// the busy flag, the dropped-request flag, the interrupt level and the
// chip-select output.
// The request is processed in the cycle it is accepted and its result
// appears registered on the next cycle.
// Throughput is one request per cycle while the receiver takes results; the
// register file, FIFO pointers and run sequencer are all updated in a single pass per request.
// While the receiver stalls, the result is held and s_tready drops, so no
// further request is taken until the pending result is taken; a request is
// accepted in the same cycle the held result leaves.
// Synchronous active-low reset clears the register file, FIFO levels and
// run phase; FIFO storage holds no defined value until written.
module spi_master_fifo_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: address[7:0], write_data[39:8], reply_byte[47:40], cs_level[48]
    input  logic [55:0] s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: read_data[31:0], shift_valid[32], shift_byte[40:33],
    // busy_res[41], ignored[42], irq_level[43], cs_out[44]
    output logic [47:0] m_tdata
);
    import spimf_pkg::*;

    logic          accept;
    logic          m_valid_reg;
    spimf_result_t res;
    spimf_result_t res_reg;

    // The result register frees up when its contents are being taken.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    spimf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .command    (s_tuser),
        .address    (s_tdata[7:0]),
        .write_data (s_tdata[39:8]),
        .reply_byte (s_tdata[47:40]),
        .cs_level   (s_tdata[48]),
        .result     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_reg.cs_out, res_reg.irq_level, res_reg.ignored,
                       res_reg.busy_res, res_reg.shift_byte, res_reg.shift_valid,
                       res_reg.read_data};

endmodule

// File: verif/spi_master_fifo_controller_tb.sv
// Self-checking testbench for the SPI master FIFO controller: drives register,
// reply and chip-select requests and checks every result against a predictor.
// Depends on spimf_pkg and the spi_master_fifo_controller RTL.
`timescale 1ns / 100ps

module spi_master_fifo_controller_tb;
    import spimf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    spi_master_fifo_controller u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // One bus request as the sender sees it.
    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [7:0]  reply;
        logic        cs;
    } spi_req_t;

    // A directed row; when has_exp is set the result is also compared with
    // the typed-in value, otherwise only the predictor is used.
    typedef struct {
        spi_req_t      req;
        bit            has_exp;
        spimf_result_t exp;
    } dir_row_t;

    // Predictor state: a private copy of the controller.
    logic [31:0] regs [REG_WORDS];
    logic [31:0] txq [FIFO_DEPTH];
    logic [31:0] rxq [FIFO_DEPTH];
    int unsigned tx_hd, tx_lv, rx_hd, rx_lv;
    phase_t      phase;
    logic [31:0] out_word, in_word;
    int unsigned byte_ix;
    bit          emitted;
    logic [7:0]  emitted_byte;

    spimf_result_t expected_results[$];
    int            error_count;
    int            cycle_count;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    bit            hold_receiver;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned word_len();
        case (regs[IX_CFG][16:15])
            2'd0:    return 1;
            2'd1:    return 2;
            default: return 4;
        endcase
    endfunction

    function automatic void send_byte(input logic [7:0] b);
        emitted = 1'b1;
        emitted_byte = b;
    endfunction

    function automatic void pick_next(input bit tx_ok);
        if (tx_ok && regs[IX_TXCNT] != 0 && tx_lv != 0) begin
            out_word = txq[tx_hd];
            tx_hd = (tx_hd + 1) % FIFO_DEPTH;
            tx_lv--;
            in_word = '0;
            byte_ix = 0;
            phase = PH_TX;
            send_byte(out_word[7:0]);
        end else if (rx_lv < FIFO_DEPTH && regs[IX_RXCNT] != 0 && regs[IX_CFG][0]) begin
            in_word = '0;
            byte_ix = 0;
            phase = PH_FILL;
            send_byte(8'hFF);
        end else begin
            phase = PH_IDLE;
            if (regs[IX_RXCNT] == 0 && regs[IX_TXCNT] == 0)
                regs[IX_STATUS] |= ST_COMPLETE;
        end
    endfunction

    function automatic void try_start();
        logic [1:0] mode;
        mode = regs[IX_CFG][6:5];
        if (mode == MODE_DMA || mode == MODE_INVALID) return;
        if (!regs[IX_CTRL][0]) return;
        if ((regs[IX_RXCNT] | regs[IX_TXCNT]) == 0) return;
        if (tx_lv == 0) regs[IX_STATUS] |= ST_TXEMPTY;
        pick_next(1'b1);
    endfunction

    function automatic void take_reply(input logic [7:0] b);
        bit was_tx;
        was_tx = (phase == PH_TX);
        in_word = {in_word[23:0], b};
        if (byte_ix + 1 < word_len()) begin
            byte_ix = (byte_ix + 1) & 3;
            if (was_tx) begin
                out_word = out_word >> 8;
                send_byte(out_word[7:0]);
            end else begin
                send_byte(8'hFF);
            end
            return;
        end
        if (was_tx) begin
            regs[IX_TXCNT] = regs[IX_TXCNT] - 1;
            if (tx_lv == 0) regs[IX_STATUS] |= ST_TXEMPTY;
            if (regs[IX_RXCNT] == 0) begin
                pick_next(1'b1);
                return;
            end
        end
        if (rx_lv >= FIFO_DEPTH) begin
            regs[IX_STATUS] |= ST_RXOVF;
            phase = PH_IDLE;
            return;
        end
        rxq[(rx_hd + rx_lv) % FIFO_DEPTH] = in_word;
        rx_lv++;
        regs[IX_RXCNT] = regs[IX_RXCNT] - 1;
        regs[IX_STATUS] |= ST_RXREADY;
        pick_next(was_tx);
    endfunction

    function automatic void reg_write(input logic [7:0] addr, input logic [31:0] val);
        bit          kick;
        logic [31:0] w;
        kick = 1'b0;
        if (addr >= ADDR_LIMIT) return;
        case (addr)
            ADDR_CTRL: begin
                if (val[2]) begin tx_hd = 0; tx_lv = 0; val[2] = 1'b0; end
                if (val[3]) begin rx_hd = 0; rx_lv = 0; val[3] = 1'b0; end
                kick = val[0];
            end
            ADDR_STATUS: val = regs[IX_STATUS] & ~val;
            ADDR_TXDATA: begin
                if (tx_lv >= FIFO_DEPTH) begin
                    val = '0;
                end else begin
                    w = val;
                    if (word_len() == 1) w &= 32'hFF;
                    else if (word_len() == 2) w &= 32'hFFFF;
                    txq[(tx_hd + tx_lv) % FIFO_DEPTH] = w;
                    tx_lv++;
                    kick = 1'b1;
                end
            end
            ADDR_CFG, ADDR_RXCNT, ADDR_TXCNT: kick = 1'b1;
            default: ;
        endcase
        regs[addr >> 2] = val;
        if (kick) try_start();
    endfunction

    function automatic logic [31:0] reg_read(input logic [7:0] addr);
        logic [31:0] r;
        if (addr >= ADDR_LIMIT) return '0;
        r = regs[addr >> 2];
        if (addr == ADDR_RXDATA) begin
            if (rx_lv == 0) return '0;
            r = rxq[rx_hd];
            rx_hd = (rx_hd + 1) % FIFO_DEPTH;
            rx_lv--;
            if (rx_lv == 0) try_start();
        end else if (addr == ADDR_STATUS) begin
            r[15:6] = {rx_lv[4:0], tx_lv[4:0]};
        end
        return r;
    endfunction

    // Works out the result of one accepted request and updates the copy.
    function automatic spimf_result_t predict_spi_result(input spi_req_t q);
        spimf_result_t res;
        logic [31:0]   mask;
        res = '0;
        emitted = 1'b0;
        emitted_byte = '0;
        case (q.cmd)
            CMD_CS:    regs[IX_PIN][1] = q.cs;
            CMD_REPLY: if (phase != PH_IDLE) take_reply(q.reply);
            default: begin
                if (phase != PH_IDLE) res.ignored = 1'b1;
                else if (q.cmd == CMD_WRITE) reg_write(q.addr, q.wdata);
                else res.read_data = reg_read(q.addr);
            end
        endcase
        mask = '0;
        if (regs[IX_CFG][7]) mask |= ST_RXREADY;
        if (regs[IX_CFG][8]) mask |= ST_TXEMPTY;
        if (regs[IX_CFG][21]) mask |= ST_COMPLETE;
        res.shift_valid = emitted;
        res.shift_byte = emitted ? emitted_byte : 8'h00;
        res.busy_res = (phase != PH_IDLE);
        res.irq_level = (regs[IX_STATUS] & mask) != 0;
        res.cs_out = regs[IX_PIN][1];
        return res;
    endfunction

    function automatic spimf_result_t mk(input logic [31:0] rd, input logic irq,
                                         input logic cs);
        spimf_result_t r;
        r = '0;
        r.read_data = rd;
        r.irq_level = irq;
        r.cs_out = cs;
        return r;
    endfunction

    function automatic spi_req_t rq(input logic [1:0] c, input logic [7:0] a,
                                    input logic [31:0] d, input logic [7:0] rb,
                                    input logic cs);
        spi_req_t q;
        q.cmd = c; q.addr = a; q.wdata = d; q.reply = rb; q.cs = cs;
        return q;
    endfunction

    // Drives one request from a falling edge, waits for its acceptance and
    // makes the prediction once per accepted request.
    task automatic send_and_predict(input spi_req_t q, input bit has_exp,
                                    input spimf_result_t exp);
        spimf_result_t p;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.cmd;
        s_tdata <= {7'd0, q.cs, q.reply, q.wdata, q.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_spi_result(q);
        if (has_exp && p != exp)
            report_mismatch("directed row vs predictor", p.read_data, exp.read_data);
        expected_results.push_back(p);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Random request, biased toward well-formed transfer runs. Register accesses
    // pick evenly among the named registers, with one in ten at a random address.
    function automatic spi_req_t rand_req();
        spi_req_t    q;
        int unsigned k;
        logic [7:0]  pick [8];
        pick = '{ADDR_CTRL, ADDR_CFG, ADDR_STATUS, ADDR_TXDATA, ADDR_RXDATA,
                 ADDR_RXCNT, ADDR_TXCNT, 8'h0c};
        q = rq(CMD_READ, '0, $urandom(), 8'($urandom_range(255)), 1'($urandom_range(1)));
        k = $urandom_range(99);
        if (phase != PH_IDLE && k < 75) begin
            q.cmd = CMD_REPLY;
        end else if (k < 82) begin
            q.cmd = CMD_CS;
        end else if (k < 88) begin
            q.cmd = CMD_REPLY;
        end else begin
            q.cmd = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
            q.addr = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : pick[$urandom_range(7)];
            case (q.addr)
                ADDR_CTRL:   q.wdata = ($urandom_range(7) == 0) ? $urandom()
                                       : 32'($urandom_range(15)) | 32'h1;
                ADDR_CFG:    q.wdata = ($urandom_range(7) == 0) ? $urandom()
                                       : {10'd0, 1'($urandom_range(1)), 4'd0,
                                          2'($urandom_range(3)), 6'd0,
                                          2'($urandom_range(3)),
                                          2'($urandom_range(3)), 4'd0,
                                          1'($urandom_range(1))};
                ADDR_RXCNT, ADDR_TXCNT:
                             q.wdata = ($urandom_range(15) == 0) ? $urandom()
                                       : 32'($urandom_range(6));
                ADDR_STATUS: q.wdata = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF
                                                                 : $urandom();
                default: ;
            endcase
        end
        return q;
    endfunction

    // Receiver side: stalls at random, or holds off completely on request.
    always @(negedge aclk) begin
        if (!aresetn || hold_receiver)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result checker, sampled at the rising edge.
    always @(posedge aclk) begin
        spimf_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.read_data   = m_tdata[31:0];
            got.shift_valid = m_tdata[32];
            got.shift_byte  = m_tdata[40:33];
            got.busy_res    = m_tdata[41];
            got.ignored     = m_tdata[42];
            got.irq_level   = m_tdata[43];
            got.cs_out      = m_tdata[44];
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", got.read_data, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.shift_valid !== want.shift_valid)
                    report_mismatch("shift_valid", got.shift_valid, want.shift_valid);
                if (got.shift_byte !== want.shift_byte)
                    report_mismatch("shift_byte", got.shift_byte, want.shift_byte);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.ignored !== want.ignored)
                    report_mismatch("ignored", got.ignored, want.ignored);
                if (got.irq_level !== want.irq_level)
                    report_mismatch("irq_level", got.irq_level, want.irq_level);
                if (got.cs_out !== want.cs_out)
                    report_mismatch("cs_out", got.cs_out, want.cs_out);
            end
        end
    end

    // Watchdog: the whole run is bounded by a generous cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    dir_row_t dir_rows[$];

    initial begin
        int i;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_READ;
        m_tready = 1'b0;
        hold_receiver = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        for (i = 0; i < REG_WORDS; i++) regs[i] = '0;
        tx_hd = 0; tx_lv = 0; rx_hd = 0; rx_lv = 0;
        phase = PH_IDLE;
        out_word = '0; in_word = '0; byte_ix = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: reset values, extremes, ignored addresses, a 32-bit
        // word sent low byte first, an auto-generate fill, a dropped request
        // while busy and reads of an empty RX FIFO.
        dir_rows = '{
            '{rq(CMD_READ, ADDR_STATUS, '0, '0, 0), 1, mk(32'h0, 0, 0)},
            '{rq(CMD_READ, ADDR_RXDATA, '0, '0, 0), 1, mk(32'h0, 0, 0)},
            '{rq(CMD_REPLY, '0, '0, 8'hFF, 0), 1, mk(32'h0, 0, 0)},
            '{rq(CMD_CS, '0, '0, '0, 1), 1, mk(32'h0, 0, 1)},
            '{rq(CMD_WRITE, 8'hFF, 32'hFFFF_FFFF, '0, 0), 1, mk(32'h0, 0, 1)},
            '{rq(CMD_READ, 8'hFF, '0, '0, 0), 1, mk(32'h0, 0, 1)},
            '{rq(CMD_WRITE, 8'h2B, 32'hDEAD_BEEF, '0, 0), 0, '0},
            '{rq(CMD_READ, 8'h28, '0, '0, 0), 1, mk(32'hDEAD_BEEF, 0, 1)},
            '{rq(CMD_WRITE, ADDR_CFG, 32'h0021_81A0, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_RXCNT, 32'd1, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_TXCNT, 32'd1, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_TXDATA, 32'h1122_3344, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_CTRL, 32'h1, '0, 0), 0, '0},
            '{rq(CMD_READ, ADDR_STATUS, '0, '0, 0), 0, '0},
            '{rq(CMD_REPLY, '0, '0, 8'hA1, 0), 0, '0},
            '{rq(CMD_CS, '0, '0, '0, 0), 0, '0},
            '{rq(CMD_REPLY, '0, '0, 8'hB2, 0), 0, '0},
            '{rq(CMD_REPLY, '0, '0, 8'hC3, 0), 0, '0},
            '{rq(CMD_REPLY, '0, '0, 8'h00, 0), 0, '0},
            '{rq(CMD_READ, ADDR_RXDATA, '0, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_CFG, 32'h0000_0061, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_RXCNT, 32'd1, '0, 0), 0, '0},
            '{rq(CMD_REPLY, '0, '0, 8'h5A, 0), 0, '0},
            '{rq(CMD_READ, ADDR_RXDATA, '0, '0, 0), 0, '0},
            '{rq(CMD_WRITE, ADDR_STATUS, 32'hFFFF_FFFF, '0, 0), 0, '0}
        };
        foreach (dir_rows[r])
            send_and_predict(dir_rows[r].req, dir_rows[r].has_exp, dir_rows[r].exp);
        drain();

        // Back-pressure: the receiver holds off while requests keep coming.
        hold_receiver = 1'b1;
        fork
            begin
                for (i = 0; i < 6; i++)
                    send_and_predict(rq(CMD_CS, '0, '0, '0, 1'(i)), 0, '0);
            end
            begin
                repeat (60) @(negedge aclk);
                hold_receiver = 1'b0;
            end
        join
        drain();

        // Random phases with different idling on both sides.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            for (i = 0; i < 100; i++)
                send_and_predict(rand_req(), 0, '0);
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        drain();
        repeat (10) @(negedge aclk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/spimf_pkg.sv
rtl/core/spimf_core.sv
rtl/core/spi_master_fifo_controller.sv
verif/spi_master_fifo_controller_tb.sv
